// ===== sv/att_pkg.sv =====
// ----------------------------------------------------------------------------
// att_pkg
// shared types and constants of the alarm timer table
// ----------------------------------------------------------------------------
`default_nettype none
package att_pkg;
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;
    localparam logic [15:0] MIN_REPEAT_RESET = 16'd10;
    localparam logic [12:0] COUNT_MAX = 13'd8191;

    localparam logic [2:0] FUNC_SET        = 3'd0;
    localparam logic [2:0] FUNC_REMOVE     = 3'd1;
    localparam logic [2:0] FUNC_REMOVE_ALL = 3'd2;
    localparam logic [2:0] FUNC_TICK       = 3'd3;
    localparam logic [2:0] FUNC_CLEAR      = 3'd4;

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_FIRED = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  owner_id;
        logic [15:0] alarm_number;
        logic [31:0] interval_ms;
        logic        repeat_req;
        logic [15:0] delta_ms;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [7:0]  fired_owner;
        logic [15:0] fired_number;
        logic [12:0] fire_count;
        logic [31:0] time_left_ms;
        logic        last;
    } rsp_t;
endpackage
`default_nettype wire

// ===== sv/att_divider.sv =====
// ----------------------------------------------------------------------------
// att_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module att_divider #(
    parameter int W = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              busy,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);
    localparam int CW = $clog2(W + 1);
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  q_reg, r_reg, d_reg;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    always_comb
    begin
        shifted = {r_reg, q_reg[W-1]};
        trial   = shifted - {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[W])
            begin
                r_reg <= trial[W-1:0];
                q_reg <= {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted[W-1:0];
                q_reg <= {q_reg[W-2:0], 1'b0};
            end
        end
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule
`default_nettype wire

// ===== sv/alarm_timer_table.sv =====
// ----------------------------------------------------------------------------
// alarm_timer_table
// age-ordered table of one-shot and periodic alarms
// ----------------------------------------------------------------------------
// the table holds up to TABLE_DEPTH alarms in flip-flops, in age order. every
// request is worked by a small sequencer; remove, remove-all and tick walk the
// entries one a cycle, but a tick stalls at each firing entry. tick walks each
// entry once and then compacts the table one entry a cycle; a periodic firing
// runs the shared bit-serial divider before its result is sent. each result
// sits in the single output register until taken; a firing that finds the
// register still full waits there, and a new request is only taken once the
// last result has left.
`default_nettype none
module alarm_timer_table #(
    parameter int TABLE_DEPTH = att_pkg::TABLE_DEPTH_DEF,
    parameter int TIME_BITS   = att_pkg::TIME_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire att_pkg::req_t in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output att_pkg::rsp_t     out_data,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata
);
    import att_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

    // sequencer states, one-hot
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SCAN  = 8'b00000010,
        S_TICK  = 8'b00000100,
        S_DIV   = 8'b00001000,
        S_FIRE  = 8'b00010000,
        S_PACK  = 8'b00100000,
        S_REPLY = 8'b01000000,
        S_WAIT  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] min_rep_reg;

    // table storage
    logic                 valid_reg  [TABLE_DEPTH];
    logic                 marked_reg [TABLE_DEPTH];
    logic [7:0]           owner_reg  [TABLE_DEPTH];
    logic [15:0]          number_reg [TABLE_DEPTH];
    logic [TIME_BITS-1:0] ivl_reg    [TABLE_DEPTH];
    logic [TIME_BITS-1:0] rem_reg    [TABLE_DEPTH];
    logic                 per_reg    [TABLE_DEPTH];
    logic [CW-1:0]        count_reg;

    req_t                 req_reg;
    logic [CW-1:0]        idx_reg;   // read index
    logic [CW-1:0]        wr_reg;    // compaction write index
    logic [TIME_BITS-1:0] left_reg;
    logic [TIME_BITS-1:0] over_reg;
    rsp_t                 rsp_reg;
    logic                 ovalid_reg;

    // shared divider for periodic catch-up
    logic                 div_start;
    logic                 div_busy;
    logic [TIME_BITS-1:0] div_q, div_r, div_d;

    att_divider #(.W(TIME_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (over_reg),
        .divisor  (div_d),
        .busy     (div_busy),
        .quotient (div_q),
        .remainder(div_r)
    );

    logic [IW-1:0]        ix;
    logic [IW-1:0]        wx;
    logic                 in_range;
    logic [TIME_BITS-1:0] delta_w;
    logic [TIME_BITS-1:0] ivl_in;
    logic                 out_free;
    logic                 accept;

    assign ix       = idx_reg[IW-1:0];
    assign wx       = wr_reg[IW-1:0];
    assign in_range = (idx_reg < count_reg);
    assign delta_w  = TIME_BITS'(req_reg.delta_ms);
    assign div_d    = (ivl_reg[ix] == '0) ? TIME_BITS'(1) : ivl_reg[ix];
    assign out_free = !ovalid_reg || out_ready;
    // a request is taken only once the previous result has left
    assign in_ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign accept   = in_valid && in_ready;
    assign out_valid = ovalid_reg;
    assign out_data  = rsp_reg;

    // interval saturated to the time width
    always_comb
    begin
        if (TIME_BITS >= 32)
        begin
            ivl_in = TIME_BITS'(in_data.interval_ms);
        end
        else if ((in_data.interval_ms >> TIME_BITS) != '0)
        begin
            ivl_in = TMAX;
        end
        else
        begin
            ivl_in = TIME_BITS'(in_data.interval_ms);
        end
    end

    logic live;
    logic fires;
    assign live  = in_range && valid_reg[ix] && !marked_reg[ix];
    assign fires = !(delta_w < rem_reg[ix]);

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.func)
                        FUNC_REMOVE, FUNC_REMOVE_ALL: state_next = S_SCAN;
                        FUNC_TICK:                    state_next = S_TICK;
                        default:                      state_next = S_REPLY;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!in_range)
                begin
                    state_next = S_REPLY;
                end
            end
            S_TICK:
            begin
                if (!in_range)
                begin
                    state_next = S_PACK;
                end
                else if (live && fires)
                begin
                    if (per_reg[ix])
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_FIRE;
                    end
                end
            end
            S_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_FIRE;
            end
            S_FIRE:
            begin
                if (!div_busy && out_free)
                begin
                    state_next = S_TICK;
                end
            end
            S_PACK:
            begin
                if (!in_range && out_free)
                begin
                    state_next = S_WAIT;
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            min_rep_reg <= MIN_REPEAT_RESET;
            count_reg   <= '0;
            ovalid_reg  <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                valid_reg[i]  <= 1'b0;
                marked_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                min_rep_reg <= cfg_wdata;
            end
            if (ovalid_reg && out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && in_data.func == FUNC_CLEAR)
                    begin
                        count_reg <= '0;
                        for (int i = 0; i < TABLE_DEPTH; i++)
                        begin
                            valid_reg[i]  <= 1'b0;
                            marked_reg[i] <= 1'b0;
                        end
                    end
                    else if (accept && in_data.func == FUNC_SET &&
                             in_data.interval_ms != '0 &&
                             !(in_data.repeat_req &&
                               in_data.interval_ms < 32'(min_rep_reg)) &&
                             count_reg < CW'(TABLE_DEPTH))
                    begin
                        valid_reg[count_reg[IW-1:0]]  <= 1'b1;
                        marked_reg[count_reg[IW-1:0]] <= 1'b0;
                        count_reg <= count_reg + 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (in_range && valid_reg[ix] &&
                        owner_reg[ix] == req_reg.owner_id &&
                        (req_reg.func == FUNC_REMOVE_ALL ||
                         number_reg[ix] == req_reg.alarm_number))
                    begin
                        marked_reg[ix] <= 1'b1;
                    end
                end
                S_TICK:
                begin
                    if (live && fires && !per_reg[ix])
                    begin
                        valid_reg[ix] <= 1'b0;
                    end
                end
                S_PACK:
                begin
                    if (in_range)
                    begin
                        if (valid_reg[ix] && !marked_reg[ix])
                        begin
                            valid_reg[wx]  <= 1'b1;
                            marked_reg[wx] <= 1'b0;
                            if (wx != ix)
                            begin
                                valid_reg[ix]  <= 1'b0;
                                marked_reg[ix] <= 1'b0;
                            end
                        end
                        else
                        begin
                            valid_reg[ix]  <= 1'b0;
                            marked_reg[ix] <= 1'b0;
                        end
                    end
                    else if (out_free)
                    begin
                        count_reg  <= wr_reg;
                        ovalid_reg <= 1'b1;
                    end
                end
                S_FIRE:
                begin
                    if (!div_busy && out_free)
                    begin
                        ovalid_reg <= 1'b1;
                    end
                end
                S_REPLY:
                begin
                    if (out_free)
                    begin
                        ovalid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                req_reg  <= in_data;
                idx_reg  <= '0;
                wr_reg   <= '0;
                left_reg <= '0;
                if (accept && in_data.func == FUNC_SET &&
                    count_reg < CW'(TABLE_DEPTH))
                begin
                    owner_reg[count_reg[IW-1:0]]  <= in_data.owner_id;
                    number_reg[count_reg[IW-1:0]] <= in_data.alarm_number;
                    ivl_reg[count_reg[IW-1:0]]    <= ivl_in;
                    rem_reg[count_reg[IW-1:0]]    <= ivl_in;
                    per_reg[count_reg[IW-1:0]]    <= in_data.repeat_req;
                end
                // set status is worked out here and kept in the response
                if (accept)
                begin
                    rsp_reg <= '0;
                    rsp_reg.kind <= KIND_REPLY;
                    rsp_reg.last <= 1'b1;
                    if (in_data.func == FUNC_SET)
                    begin
                        if (in_data.interval_ms == '0 ||
                            (in_data.repeat_req &&
                             in_data.interval_ms < 32'(min_rep_reg)))
                        begin
                            rsp_reg.status <= STAT_INVALID;
                        end
                        else if (count_reg >= CW'(TABLE_DEPTH))
                        begin
                            rsp_reg.status <= STAT_FULL;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (in_range)
                begin
                    if (req_reg.func == FUNC_REMOVE && valid_reg[ix] &&
                        owner_reg[ix] == req_reg.owner_id &&
                        number_reg[ix] == req_reg.alarm_number)
                    begin
                        left_reg <= rem_reg[ix];
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                else
                begin
                    // saturate time left to 32 bits
                    if (TIME_BITS > 32 && (left_reg >> 32) != '0)
                    begin
                        rsp_reg.time_left_ms <= 32'hFFFF_FFFF;
                    end
                    else
                    begin
                        rsp_reg.time_left_ms <= 32'(left_reg);
                    end
                end
            end
            S_TICK:
            begin
                if (!in_range)
                begin
                    idx_reg <= '0;
                end
                else if (live && fires)
                begin
                    over_reg <= delta_w - rem_reg[ix];
                end
                else
                begin
                    if (live)
                    begin
                        rem_reg[ix] <= rem_reg[ix] - delta_w;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            S_FIRE:
            begin
                if (!div_busy && out_free)
                begin
                    rsp_reg              <= '0;
                    rsp_reg.kind         <= KIND_FIRED;
                    rsp_reg.fired_owner  <= owner_reg[ix];
                    rsp_reg.fired_number <= number_reg[ix];
                    if (per_reg[ix])
                    begin
                        if (div_q >= TIME_BITS'(COUNT_MAX))
                        begin
                            rsp_reg.fire_count <= COUNT_MAX;
                        end
                        else
                        begin
                            rsp_reg.fire_count <= 13'(div_q) + 13'd1;
                        end
                        rem_reg[ix] <= div_d - div_r;
                    end
                    else
                    begin
                        rsp_reg.fire_count <= 13'd1;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            S_PACK:
            begin
                if (in_range)
                begin
                    if (valid_reg[ix] && !marked_reg[ix])
                    begin
                        owner_reg[wx]  <= owner_reg[ix];
                        number_reg[wx] <= number_reg[ix];
                        ivl_reg[wx]    <= ivl_reg[ix];
                        rem_reg[wx]    <= rem_reg[ix];
                        per_reg[wx]    <= per_reg[ix];
                        wr_reg         <= wr_reg + 1'b1;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                else if (out_free)
                begin
                    rsp_reg      <= '0;
                    rsp_reg.kind <= KIND_DONE;
                    rsp_reg.last <= 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// testbench of the alarm timer table: a predictor of the table drives the
// expected replies, firings and tick-done items, compared field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
    import att_pkg::*;

    localparam int DEPTH     = 16;
    localparam int WATCHDOG  = 20000;
    localparam int MAX_SHOWN = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    req_t        in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    rsp_t        out_data;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    // idle phase: 0 sender 17 / receiver 71, 1 the other way, 2 no idling
    int          idle_phase = 0;
    bit          hold_sender = 1'b0;

    req_t        pending_reqs[$];
    rsp_t        expected_rsps[$];
    int          mismatches = 0;
    int          stray_rsps = 0;
    int          reqs_sent = 0;
    int          rsps_seen = 0;
    int          fires_seen = 0;
    int          quiet_cycles = 0;

    // predictor state
    logic [15:0] min_repeat = MIN_REPEAT_RESET;
    bit          tab_valid[DEPTH];
    bit          tab_marked[DEPTH];
    logic [7:0]  tab_owner[DEPTH];
    logic [15:0] tab_number[DEPTH];
    logic [31:0] tab_interval[DEPTH];
    logic [31:0] tab_remaining[DEPTH];
    bit          tab_periodic[DEPTH];
    int          tab_count = 0;

    alarm_timer_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // append helpers for the two queues
    function automatic void expect_rsp(rsp_t r);
        expected_rsps = {expected_rsps, r};
    endfunction

    function automatic void queue_req(req_t q);
        pending_reqs = {pending_reqs, q};
    endfunction

    function automatic rsp_t reply(logic [1:0] st, logic [31:0] left);
        rsp_t r;
        r = '0;
        r.kind = KIND_REPLY;
        r.status = st;
        r.time_left_ms = left;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void wipe_alarms();
        for (int i = 0; i < DEPTH; i++)
        begin
            tab_valid[i] = 1'b0;
            tab_marked[i] = 1'b0;
        end
        tab_count = 0;
    endfunction

    // works out every result a request causes, and updates the table copy
    function automatic void predict_alarms(req_t q);
        rsp_t        r;
        logic [31:0] left;
        logic [31:0] over;
        logic [31:0] k;
        int          w;
        case (q.func)
            FUNC_SET:
            begin
                if (q.interval_ms == 0 || (q.repeat_req && q.interval_ms < min_repeat))
                    expect_rsp(reply(STAT_INVALID, '0));
                else if (tab_count >= DEPTH)
                    expect_rsp(reply(STAT_FULL, '0));
                else
                begin
                    tab_valid[tab_count] = 1'b1;
                    tab_marked[tab_count] = 1'b0;
                    tab_owner[tab_count] = q.owner_id;
                    tab_number[tab_count] = q.alarm_number;
                    tab_interval[tab_count] = q.interval_ms;
                    tab_remaining[tab_count] = q.interval_ms;
                    tab_periodic[tab_count] = q.repeat_req;
                    tab_count++;
                    expect_rsp(reply(STAT_OK, '0));
                end
            end
            FUNC_REMOVE:
            begin
                left = '0;
                for (int i = 0; i < tab_count; i++)
                    if (tab_valid[i] && tab_owner[i] == q.owner_id
                        && tab_number[i] == q.alarm_number)
                    begin
                        tab_marked[i] = 1'b1;
                        left = tab_remaining[i];
                    end
                expect_rsp(reply(STAT_OK, left));
            end
            FUNC_REMOVE_ALL:
            begin
                for (int i = 0; i < tab_count; i++)
                    if (tab_valid[i] && tab_owner[i] == q.owner_id)
                        tab_marked[i] = 1'b1;
                expect_rsp(reply(STAT_OK, '0));
            end
            FUNC_TICK:
            begin
                for (int i = 0; i < tab_count; i++)
                begin
                    if (!tab_valid[i] || tab_marked[i])
                        continue;
                    if (32'(q.delta_ms) < tab_remaining[i])
                    begin
                        tab_remaining[i] -= 32'(q.delta_ms);
                        continue;
                    end
                    over = 32'(q.delta_ms) - tab_remaining[i];
                    if (tab_periodic[i])
                    begin
                        k = over / tab_interval[i] + 32'd1;
                        if (k > 32'(COUNT_MAX))
                            k = 32'(COUNT_MAX);
                        tab_remaining[i] = tab_interval[i] - over % tab_interval[i];
                    end
                    else
                    begin
                        k = 32'd1;
                        tab_valid[i] = 1'b0;
                    end
                    r = '0;
                    r.kind = KIND_FIRED;
                    r.fired_owner = tab_owner[i];
                    r.fired_number = tab_number[i];
                    r.fire_count = k[12:0];
                    expect_rsp(r);
                end
                // compaction keeps the age order
                w = 0;
                for (int i = 0; i < tab_count; i++)
                begin
                    if (!tab_valid[i] || tab_marked[i])
                        continue;
                    tab_owner[w] = tab_owner[i];
                    tab_number[w] = tab_number[i];
                    tab_interval[w] = tab_interval[i];
                    tab_remaining[w] = tab_remaining[i];
                    tab_periodic[w] = tab_periodic[i];
                    tab_valid[w] = 1'b1;
                    tab_marked[w] = 1'b0;
                    w++;
                end
                for (int i = w; i < DEPTH; i++)
                begin
                    tab_valid[i] = 1'b0;
                    tab_marked[i] = 1'b0;
                end
                tab_count = w;
                r = '0;
                r.kind = KIND_DONE;
                r.last = 1'b1;
                expect_rsp(r);
            end
            FUNC_CLEAR:
            begin
                wipe_alarms();
                expect_rsp(reply(STAT_OK, '0));
            end
            default:
                expect_rsp(reply(STAT_OK, '0));
        endcase
    endfunction

    function automatic req_t make_req(logic [2:0] f, logic [7:0] own, logic [15:0] num,
                                      logic [31:0] ivl, bit rep, logic [15:0] dt);
        req_t q;
        q.func = f;
        q.owner_id = own;
        q.alarm_number = num;
        q.interval_ms = ivl;
        q.repeat_req = rep;
        q.delta_ms = dt;
        return q;
    endfunction

    // mostly well-formed traffic on a few owners so that removes hit
    function automatic req_t random_req();
        req_t q;
        int   pick;
        q = make_req(3'($urandom), 8'($urandom), 16'($urandom), $urandom,
                     1'($urandom), 16'($urandom));
        q.owner_id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        q.alarm_number = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            q.func = FUNC_SET;
            case ($urandom_range(0, 5))
                0: q.interval_ms = $urandom_range(0, 20);
                1: q.interval_ms = $urandom;
                default: q.interval_ms = $urandom_range(1, 3000);
            endcase
        end
        else if (pick < 52)
            q.func = FUNC_REMOVE;
        else if (pick < 57)
            q.func = FUNC_REMOVE_ALL;
        else if (pick < 90)
        begin
            q.func = FUNC_TICK;
            if ($urandom_range(0, 7) == 0)
                q.delta_ms = 16'($urandom);
            else
                q.delta_ms = 16'($urandom_range(0, 1500));
        end
        else if (pick < 94)
            q.func = FUNC_CLEAR;
        else
            q.func = 3'($urandom_range(5, 7));
        return q;
    endfunction

    // driver: a request stays on the bus untouched until accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_alarms(in_data);
                reqs_sent++;
            end
            if ((!in_valid || in_ready) && pending_reqs.size() > 0 && !hold_sender
                && !(idle_phase == 0 && $urandom_range(0, 99) < 17)
                && !(idle_phase == 1 && $urandom_range(0, 99) < 71))
            begin
                in_valid <= 1'b1;
                in_data <= pending_reqs.pop_front();
            end
            else if (in_valid && in_ready)
                in_valid <= 1'b0;
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        case (idle_phase)
            0: out_ready <= ($urandom_range(0, 99) >= 71);
            1: out_ready <= ($urandom_range(0, 99) >= 17);
            default: out_ready <= 1'b1;
        endcase
    end

    // monitor: each result against the oldest expectation
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            rsps_seen++;
            if (out_data.kind == KIND_FIRED)
                fires_seen++;
            if (expected_rsps.size() == 0)
            begin
                stray_rsps++;
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result %h", out_data);
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (out_data !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"mismatch: kind %0d/%0d status %0d/%0d owner %0d/%0d",
                                  " num %0d/%0d cnt %0d/%0d left %0d/%0d last %0d/%0d"},
                                 want.kind, out_data.kind, want.status, out_data.status,
                                 want.fired_owner, out_data.fired_owner,
                                 want.fired_number, out_data.fired_number,
                                 want.fire_count, out_data.fire_count,
                                 want.time_left_ms, out_data.time_left_ms,
                                 want.last, out_data.last);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("watchdog expired, %0d results outstanding", expected_rsps.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_min_repeat(logic [15:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        min_repeat = v;
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
            queue_req(random_req());
    endtask

    initial
    begin
        wipe_alarms();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: error cases, removes, periodic catch-up, full table
        queue_req(make_req(FUNC_SET, 8'd1, 16'd1, 32'd0, 1'b0, 16'd0));
        queue_req(make_req(FUNC_SET, 8'd1, 16'd1, 32'd9, 1'b1, 16'd0));
        queue_req(make_req(FUNC_SET, 8'd1, 16'd1, 32'd10, 1'b1, 16'hffff));
        queue_req(make_req(FUNC_SET, 8'hff, 16'hffff, 32'hffffffff, 1'b0, 16'd0));
        queue_req(make_req(FUNC_SET, 8'd0, 16'd0, 32'd1, 1'b0, 16'd0));
        queue_req(make_req(FUNC_SET, 8'd2, 16'd7, 32'd3, 1'b0, 16'd0));
        queue_req(make_req(FUNC_REMOVE, 8'hff, 16'hffff, 32'd0, 1'b0, 16'd0));
        queue_req(make_req(FUNC_REMOVE, 8'd9, 16'd9, 32'd0, 1'b0, 16'd0));
        queue_req(make_req(FUNC_REMOVE_ALL, 8'd2, 16'd0, 32'd0, 1'b0, 16'd0));
        queue_req(make_req(FUNC_REMOVE, 8'd2, 16'd7, 32'd0, 1'b0, 16'd0));
        queue_req(make_req(FUNC_TICK, 8'd0, 16'd0, 32'd0, 1'b0, 16'hffff));
        queue_req(make_req(FUNC_TICK, 8'd0, 16'd0, 32'd0, 1'b0, 16'd0));
        queue_req(make_req(3'd5, 8'd0, 16'd0, 32'd0, 1'b0, 16'd0));
        queue_req(make_req(3'd7, 8'hff, 16'hffff, 32'hffffffff, 1'b1, 16'hffff));
        for (int i = 0; i < 17; i++)
            queue_req(make_req(FUNC_SET, 8'd3, 16'(i), 32'd500, 1'b0, 16'd0));
        queue_req(make_req(FUNC_REMOVE, 8'd3, 16'd0, 32'd0, 1'b0, 16'd0));
        queue_req(make_req(FUNC_SET, 8'd3, 16'd99, 32'd500, 1'b0, 16'd0));
        queue_req(make_req(FUNC_TICK, 8'd0, 16'd0, 32'd0, 1'b0, 16'd600));
        queue_req(make_req(FUNC_CLEAR, 8'd0, 16'd0, 32'd0, 1'b0, 16'd0));
        drain();

        // smallest minimum: interval 1 periodic saturates the fire count
        write_min_repeat(16'd1);
        queue_req(make_req(FUNC_SET, 8'd4, 16'd4, 32'd1, 1'b1, 16'd0));
        queue_req(make_req(FUNC_TICK, 8'd0, 16'd0, 32'd0, 1'b0, 16'hffff));
        queue_random(70);
        drain();

        // sender held back while requests are queued, then released
        hold_sender = 1'b1;
        queue_random(5);
        repeat (50) @(posedge clk);
        hold_sender = 1'b0;
        drain();

        idle_phase = 1;
        write_min_repeat(16'hffff);
        queue_random(60);
        drain();

        idle_phase = 2;
        write_min_repeat(16'd37);
        queue_random(70);
        drain();

        $display("%0d requests, %0d results (%0d firings), minimums 10 / 1 / 65535 / 37",
                 reqs_sent, rsps_seen, fires_seen);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("Verification passed");
        else
        begin
            $display("%0d mismatches, %0d unexpected", mismatches, stray_rsps);
            $display("Verification failed");
        end
        $finish;
    end
endmodule
